FILE: hw/rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Widths, stage payload types and shared constants of the byte RGB to HSV
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    localparam int PIX_W     = 8;
    localparam int Q_W       = 8;
    localparam int NUM_W     = 12;
    localparam int FULL_W    = 11;
    localparam int HUE_NUM_W = 20;
    localparam int HUE_DEN_W = 12;
    localparam int SAT_NUM_W = 17;
    localparam int SAT_DEN_W = 9;

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [PIX_W-1:0]     vmax;
        logic                 hue_zero;
        logic                 sat_zero;
    } t_div_op;

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_rem;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_rem;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [Q_W-1:0]       hue_q;
        logic [Q_W-1:0]       sat_q;
        logic [PIX_W-1:0]     vmax;
        logic                 hue_zero;
        logic                 sat_zero;
    } t_div_st;

    typedef struct packed {
        logic [Q_W-1:0]   hue_q;
        logic [Q_W-1:0]   sat_q;
        logic [PIX_W-1:0] vmax;
        logic             hue_zero;
        logic             sat_zero;
    } t_div_res;

endpackage

`default_nettype wire

FILE: hw/rtl/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two register stages: channel extremes and sector numerator, then wrap and
// the rounded numerators and denominators for hue and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_blue,
    input  logic [7:0]              i_green,
    input  logic [7:0]              i_red,
    output logic                    o_valid,
    input  logic                    i_ready,
    output rgbhsv_pkg::t_div_op     o_op
);
    import rgbhsv_pkg::*;

    logic                    r_s1_v;
    logic [PIX_W-1:0]        r_s1_vmax;
    logic [PIX_W-1:0]        r_s1_delta;
    logic signed [NUM_W-1:0] r_s1_num;
    logic                    r_s2_v;
    t_div_op                 r_s2_op;

    logic                    w_en1;
    logic                    w_en2;
    logic [PIX_W-1:0]        n_vmax;
    logic [PIX_W-1:0]        w_vmin;
    logic signed [NUM_W-1:0] n_num;
    logic [FULL_W-1:0]       w_full;
    logic signed [NUM_W-1:0] w_wrap;
    logic [FULL_W-1:0]       w_un;
    t_div_op                 n_op;

    assign w_en2   = !r_s2_v || i_ready;
    assign w_en1   = !r_s1_v || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_s2_v;
    assign o_op    = r_s2_op;

    always_comb begin
        n_vmax = (i_red > i_green) ? i_red : i_green;
        if (i_blue > n_vmax) begin
            n_vmax = i_blue;
        end
        w_vmin = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_vmin) begin
            w_vmin = i_blue;
        end
    end

    always_comb begin
        if (n_vmax == i_red) begin
            n_num = NUM_W'(i_green) - NUM_W'(i_blue);
        end else if (n_vmax == i_green) begin
            n_num = (NUM_W'(n_vmax - w_vmin) << 1) + NUM_W'(i_blue) - NUM_W'(i_red);
        end else begin
            n_num = (NUM_W'(n_vmax - w_vmin) << 2) + NUM_W'(i_red) - NUM_W'(i_green);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_s1_vmax  <= n_vmax;
            r_s1_delta <= n_vmax - w_vmin;
            r_s1_num   <= n_num;
        end
    end

    always_comb begin
        w_full = (FULL_W'(r_s1_delta) << 2) + (FULL_W'(r_s1_delta) << 1);
        if (r_s1_num < 0) begin
            w_wrap = r_s1_num + $signed(NUM_W'(w_full));
        end else if (r_s1_num >= $signed(NUM_W'(w_full))) begin
            w_wrap = r_s1_num - $signed(NUM_W'(w_full));
        end else begin
            w_wrap = r_s1_num;
        end
        w_un = w_wrap[FULL_W-1:0];

        n_op.hue_num  = (HUE_NUM_W'(w_un) << 9) - (HUE_NUM_W'(w_un) << 1)
                        + HUE_NUM_W'(w_full);
        n_op.hue_den  = (HUE_DEN_W'(r_s1_delta) << 3) + (HUE_DEN_W'(r_s1_delta) << 2);
        n_op.sat_num  = (SAT_NUM_W'(r_s1_delta) << 9) - (SAT_NUM_W'(r_s1_delta) << 1)
                        + SAT_NUM_W'(r_s1_vmax);
        n_op.sat_den  = SAT_DEN_W'(r_s1_vmax) << 1;
        n_op.vmax     = r_s1_vmax;
        n_op.hue_zero = (r_s1_delta == '0);
        n_op.sat_zero = (r_s1_vmax == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_s1_v) begin
            r_s2_op <= n_op;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rgbhsv_div_pipe.sv
// ----------------------------------------------------------------------------
// rgbhsv_div_pipe
// Restoring division pipeline for hue and saturation side by side, one
// quotient bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_div_pipe (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  rgbhsv_pkg::t_div_op     i_op,
    output logic                    o_valid,
    input  logic                    i_ready,
    output rgbhsv_pkg::t_div_res    o_res
);
    import rgbhsv_pkg::*;

    localparam int NSTG = Q_W;

    logic    r_v  [NSTG];
    t_div_st r_st [NSTG];
    logic    w_en [NSTG];
    t_div_st w_src [NSTG];
    t_div_st n_st  [NSTG];

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        w_src[0].hue_rem  = i_op.hue_num;
        w_src[0].hue_den  = i_op.hue_den;
        w_src[0].sat_rem  = i_op.sat_num;
        w_src[0].sat_den  = i_op.sat_den;
        w_src[0].hue_q    = '0;
        w_src[0].sat_q    = '0;
        w_src[0].vmax     = i_op.vmax;
        w_src[0].hue_zero = i_op.hue_zero;
        w_src[0].sat_zero = i_op.sat_zero;
        for (int k = 1; k < NSTG; k++) begin
            w_src[k] = r_st[k-1];
        end
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        localparam int BIT = NSTG - 1 - k;

        logic [HUE_NUM_W-1:0] w_sub_h;
        logic [SAT_NUM_W-1:0] w_sub_s;
        logic                 w_take_h;
        logic                 w_take_s;
        logic                 w_src_v;

        assign w_src_v = (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];

        always_comb begin
            w_sub_h  = HUE_NUM_W'(w_src[k].hue_den) << BIT;
            w_sub_s  = SAT_NUM_W'(w_src[k].sat_den) << BIT;
            w_take_h = (w_src[k].hue_rem >= w_sub_h);
            w_take_s = (w_src[k].sat_rem >= w_sub_s);
            n_st[k]  = w_src[k];
            if (w_take_h) begin
                n_st[k].hue_rem = w_src[k].hue_rem - w_sub_h;
            end
            if (w_take_s) begin
                n_st[k].sat_rem = w_src[k].sat_rem - w_sub_s;
            end
            n_st[k].hue_q = {w_src[k].hue_q[Q_W-2:0], w_take_h};
            n_st[k].sat_q = {w_src[k].sat_q[Q_W-2:0], w_take_s};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_src_v) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_ready        = w_en[0];
    assign o_valid        = r_v[NSTG-1];
    assign o_res.hue_q    = r_st[NSTG-1].hue_q;
    assign o_res.sat_q    = r_st[NSTG-1].sat_q;
    assign o_res.vmax     = r_st[NSTG-1].vmax;
    assign o_res.hue_zero = r_st[NSTG-1].hue_zero;
    assign o_res.sat_zero = r_st[NSTG-1].sat_zero;

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_to_hsv_full_byte_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_full_byte_core
// Converts one 8-bit blue, green, red pixel to hue on the full byte circle,
// saturation and value, with exact round-half-up division.
//
//   channel  direction  handshake                     payload
//   in       sink       i_in_valid / o_in_ready       i_blue, i_green, i_red
//   out      source     o_out_valid / i_out_ready     o_hue, o_saturation,
//                                                     o_brightness
//
// One pixel is accepted per cycle while the output does not stall, and each
// passes from its input transfer to the output through two front stages,
// eight divider stages that produce one quotient bit each, and the output register.
// Reset clears only the stage valid bits; the pipeline is empty after it.
// A stall on the output fills empty stages first and then holds every
// stage in place, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_full_byte_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_hue,
    output logic [7:0] o_saturation,
    output logic [7:0] o_brightness
);
    import rgbhsv_pkg::*;

    logic             w_fr_valid;
    logic             w_fr_ready;
    t_div_op          w_fr_op;
    logic             w_dv_valid;
    logic             w_dv_ready;
    t_div_res         w_dv_res;

    logic             r_v;
    logic [Q_W-1:0]   r_hue;
    logic [Q_W-1:0]   r_sat;
    logic [PIX_W-1:0] r_bri;

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_blue  (i_blue),
        .i_green (i_green),
        .i_red   (i_red),
        .o_valid (w_fr_valid),
        .i_ready (w_fr_ready),
        .o_op    (w_fr_op)
    );

    rgbhsv_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_op    (w_fr_op),
        .o_valid (w_dv_valid),
        .i_ready (w_dv_ready),
        .o_res   (w_dv_res)
    );

    assign w_dv_ready = !r_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_dv_ready) begin
            r_v <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_ready && w_dv_valid) begin
            r_hue <= w_dv_res.hue_zero ? '0 : w_dv_res.hue_q;
            r_sat <= w_dv_res.sat_zero ? '0 : w_dv_res.sat_q;
            r_bri <= w_dv_res.vmax;
        end
    end

    assign o_out_valid  = r_v;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bri;

endmodule

`default_nettype wire

FILE: hw/rtl/rgbhsv_checker.sv
// ----------------------------------------------------------------------------
// rgbhsv_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_hue,
    input logic [7:0] o_saturation,
    input logic [7:0] o_brightness
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output result dropped while stalled");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_brightness == 8'd0 |-> o_saturation == 8'd0 && o_hue == 8'd0)
        else $error("black pixel with nonzero hue or saturation");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturation == 8'd0 |-> o_hue == 8'd0)
        else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_full_byte_core rgbhsv_checker u_rgbhsv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_brightness (o_brightness)
);

`default_nettype wire
